// ----- hw/rtl/i2cms_pkg.sv -----
// Shared types and constants for the I2C master bit sequencer.
// No dependencies.
`default_nettype none
package i2cms_pkg;

    localparam logic [2:0] OP_START  = 3'd0;
    localparam logic [2:0] OP_STOP   = 3'd1;
    localparam logic [2:0] OP_SEND   = 3'd2;
    localparam logic [2:0] OP_RECV   = 3'd3;
    localparam logic [2:0] OP_ACK_TX = 3'd4;
    localparam logic [2:0] OP_ACK_RX = 3'd5;

    localparam logic [7:0] MSB_MASK = 8'h80;

    // last step indexes for the send and receive commands
    localparam logic [4:0] SEND_LAST_STEP = 5'd23;
    localparam logic [4:0] RECV_LAST_STEP = 5'd16;

    typedef struct packed {
        logic [2:0] opcode;
        logic [7:0] tx_byte;
        logic       ack_to_send;
        logic [7:0] sda_samples;
    } t_cmd;

    typedef struct packed {
        logic       scl_level;
        logic       sda_level;
        logic [7:0] rx_value;
        logic       rx_valid;
        logic       last;
    } t_res;

    // queue status seen by the back end
    typedef struct packed {
        logic valid;
        logic full;
    } t_q_status;

endpackage
`default_nettype wire

// ----- hw/rtl/i2cms_if.sv -----
// Request and result channel interfaces (valid/ready with payload).
// Depends on i2cms_pkg.
`default_nettype none
interface i2cms_cmd_if;
    logic              valid;
    logic              ready;
    i2cms_pkg::t_cmd   payload;
    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

interface i2cms_res_if;
    logic              valid;
    logic              ready;
    i2cms_pkg::t_res   payload;
    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface
`default_nettype wire

// ----- hw/rtl/i2cms_front.sv -----
// Front end: accepts requests, drops unused opcodes, holds one request
// for the queue. Depends on i2cms_pkg and i2cms_if.
`default_nettype none
module i2cms_front (
    input  wire             i_clk,
    input  wire             i_rst_n,
    i2cms_cmd_if.sink       i_cmd,
    input  wire             i_push_ready,
    output logic            o_push,
    output i2cms_pkg::t_cmd o_push_cmd
);
    logic            r_valid;
    i2cms_pkg::t_cmd r_cmd;
    logic            w_take;
    logic            w_legal;

    assign w_take  = !r_valid || i_push_ready;
    assign w_legal = (i_cmd.payload.opcode <= i2cms_pkg::OP_ACK_RX);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (w_take) begin
            r_valid <= i_cmd.valid && w_legal;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_take && i_cmd.valid) begin
            r_cmd <= i_cmd.payload;
        end
    end

    assign i_cmd.ready = w_take;
    assign o_push      = r_valid;
    assign o_push_cmd  = r_cmd;
endmodule
`default_nettype wire

// ----- hw/rtl/i2cms_queue.sv -----
// Small request queue between front and back end.
// Depends on i2cms_pkg.
`default_nettype none
module i2cms_queue #(
    parameter int DEPTH = 2
) (
    input  wire                 i_clk,
    input  wire                 i_rst_n,
    input  wire                 i_push,
    input  i2cms_pkg::t_cmd     i_push_cmd,
    output logic                o_push_ready,
    input  wire                 i_pop,
    output i2cms_pkg::t_q_status o_status,
    output i2cms_pkg::t_cmd     o_head
);
    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    i2cms_pkg::t_cmd r_mem [DEPTH];
    logic [PW-1:0]   r_wr_ptr;
    logic [PW-1:0]   r_rd_ptr;
    logic [CW-1:0]   r_count;
    logic            w_wr;
    logic            w_rd;

    assign o_status.valid = (r_count != '0);
    assign o_status.full  = (r_count == CW'(DEPTH));
    assign o_push_ready   = !o_status.full;
    assign w_wr           = i_push && !o_status.full;
    assign w_rd           = i_pop && o_status.valid;
    assign o_head         = r_mem[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (w_wr) begin
                r_wr_ptr <= (r_wr_ptr == PW'(DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
            end
            if (w_rd) begin
                r_rd_ptr <= (r_rd_ptr == PW'(DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
            end
            if (w_wr && !w_rd) begin
                r_count <= r_count + 1'b1;
            end else if (w_rd && !w_wr) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_wr) begin
            r_mem[r_wr_ptr] <= i_push_cmd;
        end
    end
endmodule
`default_nettype wire

// ----- hw/rtl/i2cms_back.sv -----
// Back end: steps through the pin writes of one request, keeps the driven
// pin levels, output register. Depends on i2cms_pkg and i2cms_if.
`default_nettype none
module i2cms_back (
    input  wire                  i_clk,
    input  wire                  i_rst_n,
    input  i2cms_pkg::t_q_status i_status,
    input  i2cms_pkg::t_cmd      i_head,
    output logic                 o_pop,
    i2cms_res_if.source          o_res
);
    logic            r_busy;
    logic [2:0]      r_op;
    logic [7:0]      r_tx;
    logic            r_ack;
    logic [7:0]      r_smp;
    logic [4:0]      r_step;
    logic [1:0]      r_phase;
    logic            r_scl;
    logic            r_sda;
    logic            r_out_valid;
    i2cms_pkg::t_res r_res;

    logic            n_scl;
    logic            n_sda;
    logic [7:0]      n_rx;
    logic            n_rx_valid;
    logic            n_last;
    logic            w_adv;

    assign o_pop = !r_busy && i_status.valid;
    assign w_adv = r_busy && (!r_out_valid || o_res.ready);

    always_comb begin
        n_scl      = r_scl;
        n_sda      = r_sda;
        n_rx       = '0;
        n_rx_valid = 1'b0;
        n_last     = 1'b0;
        unique case (r_op)
            i2cms_pkg::OP_START: begin
                case (r_step[1:0])
                    2'd0:    n_sda = 1'b1;
                    2'd1:    n_scl = 1'b1;
                    2'd2:    n_sda = 1'b0;
                    default: begin
                        n_scl  = 1'b0;
                        n_last = 1'b1;
                    end
                endcase
            end
            i2cms_pkg::OP_STOP: begin
                case (r_step[1:0])
                    2'd0:    n_sda = 1'b0;
                    2'd1:    n_scl = 1'b1;
                    default: begin
                        n_sda  = 1'b1;
                        n_last = 1'b1;
                    end
                endcase
            end
            i2cms_pkg::OP_SEND: begin
                case (r_phase)
                    2'd0:    n_sda = |(r_tx & i2cms_pkg::MSB_MASK);
                    2'd1:    n_scl = 1'b1;
                    default: begin
                        n_scl  = 1'b0;
                        n_last = (r_step == i2cms_pkg::SEND_LAST_STEP);
                    end
                endcase
            end
            i2cms_pkg::OP_RECV: begin
                if (r_step == '0) begin
                    n_sda = 1'b1;
                end else if (r_step == i2cms_pkg::RECV_LAST_STEP) begin
                    n_scl      = 1'b0;
                    n_rx       = r_smp;
                    n_rx_valid = 1'b1;
                    n_last     = 1'b1;
                end else begin
                    n_scl = r_step[0];
                end
            end
            i2cms_pkg::OP_ACK_TX: begin
                case (r_step[1:0])
                    2'd0:    n_sda = r_ack;
                    2'd1:    n_scl = 1'b1;
                    default: begin
                        n_scl  = 1'b0;
                        n_last = 1'b1;
                    end
                endcase
            end
            i2cms_pkg::OP_ACK_RX: begin
                case (r_step[1:0])
                    2'd0:    n_sda = 1'b1;
                    2'd1:    n_scl = 1'b1;
                    default: begin
                        n_scl      = 1'b0;
                        n_rx       = {7'd0, |(r_smp & i2cms_pkg::MSB_MASK)};
                        n_rx_valid = 1'b1;
                        n_last     = 1'b1;
                    end
                endcase
            end
            default: n_last = 1'b1;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy      <= 1'b0;
            r_scl       <= 1'b1;
            r_sda       <= 1'b1;
            r_out_valid <= 1'b0;
            r_step      <= '0;
            r_phase     <= '0;
        end else begin
            if (o_pop) begin
                r_busy  <= 1'b1;
                r_step  <= '0;
                r_phase <= '0;
            end else if (w_adv) begin
                r_busy  <= !n_last;
                r_step  <= r_step + 1'b1;
                r_phase <= (r_phase == 2'd2) ? 2'd0 : r_phase + 1'b1;
                r_scl   <= n_scl;
                r_sda   <= n_sda;
            end
            if (w_adv) begin
                r_out_valid <= 1'b1;
            end else if (o_res.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_op  <= i_head.opcode;
            r_tx  <= i_head.tx_byte;
            r_ack <= i_head.ack_to_send;
            r_smp <= i_head.sda_samples;
        end else if (w_adv && (r_phase == 2'd2)) begin
            r_tx <= {r_tx[6:0], 1'b0};
        end
        if (w_adv) begin
            r_res.scl_level <= n_scl;
            r_res.sda_level <= n_sda;
            r_res.rx_value  <= n_rx;
            r_res.rx_valid  <= n_rx_valid;
            r_res.last      <= n_last;
        end
    end

    assign o_res.valid   = r_out_valid;
    assign o_res.payload = r_res;
endmodule
`default_nettype wire

// ----- hw/rtl/i2c_master_bit_sequencer_core.sv -----
// Top level of the I2C master bit sequencer: front end, request queue,
// back end. Depends on i2cms_pkg, i2cms_if, i2cms_front, i2cms_queue, i2cms_back.
//
// Usage: i_cmd carries one request (opcode, tx_byte, ack_to_send,
// sda_samples). o_res returns one result per pin write, in order, with the
// SCL/SDA levels driven after that write; rx_value/rx_valid carry the
// received byte or ack on the final result, which has last set.
// Results per request: start 4, stop 3, send byte 24, receive byte 17,
// send ack 3, receive ack 3. Opcodes 6 and 7 are accepted and dropped.
// Flow: a request passes the front register, the queue and the back end's
// load step before its first result is registered; then one result per
// cycle while o_res.ready is high. The back end spends a load step per
// request on top of its result count.
// The front register and the QUEUE_DEPTH-entry queue keep accepting until full
// while the back end works or the output is stalled; a stall on o_res freezes
// the back end with the current result held.
// Reset: synchronous, active low; clears the queue, drops work in flight
// and returns both driven pin levels to released (1).
`default_nettype none
module i2c_master_bit_sequencer_core #(
    parameter int QUEUE_DEPTH = 2
) (
    input  wire         i_clk,
    input  wire         i_rst_n,
    i2cms_cmd_if.sink   i_cmd,
    i2cms_res_if.source o_res
);
    logic                 w_push;
    i2cms_pkg::t_cmd      w_push_cmd;
    logic                 w_push_ready;
    logic                 w_pop;
    i2cms_pkg::t_q_status w_status;
    i2cms_pkg::t_cmd      w_head;

    i2cms_front u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd        (i_cmd),
        .i_push_ready (w_push_ready),
        .o_push       (w_push),
        .o_push_cmd   (w_push_cmd)
    );

    i2cms_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push       (w_push),
        .i_push_cmd   (w_push_cmd),
        .o_push_ready (w_push_ready),
        .i_pop        (w_pop),
        .o_status     (w_status),
        .o_head       (w_head)
    );

    i2cms_back u_back (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_status (w_status),
        .i_head   (w_head),
        .o_pop    (w_pop),
        .o_res    (o_res)
    );

    a_pop_nonempty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_pop |-> w_status.valid)
        else $error("pop from empty queue");

    a_rx_on_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_res.valid && o_res.payload.rx_valid) |-> o_res.payload.last)
        else $error("received data not on final result");

    a_rx_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_res.valid && !o_res.payload.rx_valid) |-> (o_res.payload.rx_value == 8'd0))
        else $error("rx_value nonzero without rx_valid");

    a_rx_scl_low: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_res.valid && o_res.payload.rx_valid) |-> !o_res.payload.scl_level)
        else $error("receive did not end with SCL low");
endmodule
`default_nettype wire
